// ===== hw/rtl/prrs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package prrs_pkg;

   // Default number of priority levels.
   localparam int NUM_LEVELS_DEFAULT = 4;
   // Default number of slots in each level's FIFO.
   localparam int QUEUE_DEPTH_DEFAULT = 16;
   // Width of a task id as carried on the ports and kept in the queues.
   localparam int TASK_ID_BITS = 8;
   // Width of the priority fields on the ports.
   localparam int PRIO_BITS = 3;

   localparam logic OP_ADD    = 1'b0;
   localparam logic OP_SELECT = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;

   typedef struct packed {
      logic                    op;
      logic [TASK_ID_BITS-1:0] task_id;
      logic [PRIO_BITS-1:0]    task_priority;
      logic                    running_time_left;
   } req_item_type;

   typedef struct packed {
      logic                    next_valid;
      logic [TASK_ID_BITS-1:0] next_task_id;
      logic [PRIO_BITS-1:0]    next_priority;
      logic [1:0]              status;
   } rsp_item_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic exec;
      logic finish;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic rsp_free;
   } stat_type;

endpackage

`default_nettype wire

// ===== hw/rtl/prrs_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module prrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/prrs_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module prrs_ctrl
   import prrs_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_stall,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_FINISH
   } state_type;

   state_type state_ff;
   logic      req_stall_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_stall_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff     <= ST_EXEC;
                  req_stall_ff <= 1'b1;
               end
            end
            ST_EXEC: begin
               state_ff <= ST_FINISH;
            end
            ST_FINISH: begin
               // Wait here until the output register can take the result.
               if (stat.rsp_free) begin
                  state_ff     <= ST_IDLE;
                  req_stall_ff <= 1'b0;
               end
            end
            default: begin
               state_ff     <= ST_IDLE;
               req_stall_ff <= 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      cmd.load   = (state_ff == ST_IDLE) && req_valid;
      cmd.exec   = (state_ff == ST_EXEC);
      cmd.finish = (state_ff == ST_FINISH) && stat.rsp_free;
   end

   assign req_stall = req_stall_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/prrs_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module prrs_datapath
   import prrs_pkg::*;
#(
   parameter int NUM_LEVELS  = NUM_LEVELS_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cmd_type      cmd,
   output stat_type          stat,
   input  wire req_item_type req_payload,
   input  wire logic         rsp_stall,
   output logic              rsp_valid,
   output rsp_item_type      rsp_payload
);

   localparam int LvlW     = $clog2(NUM_LEVELS);
   localparam int SlotW    = $clog2(QUEUE_DEPTH);
   localparam int CntW     = $clog2(QUEUE_DEPTH + 1);
   localparam int RamDepth = NUM_LEVELS << SlotW;
   localparam int AddrW    = LvlW + SlotW;
   localparam logic [PRIO_BITS:0]  LvlLimit = (PRIO_BITS + 1)'(NUM_LEVELS);
   localparam logic [CntW-1:0]     CntFull  = CntW'(QUEUE_DEPTH);
   localparam logic [SlotW-1:0]    SlotLast = SlotW'(QUEUE_DEPTH - 1);

   function automatic logic [SlotW-1:0] bump(input logic [SlotW-1:0] ptr);
      return (ptr == SlotLast) ? '0 : ptr + 1'b1;
   endfunction

   // Per-level FIFO control.
   logic [SlotW-1:0] head_ff  [NUM_LEVELS];
   logic [SlotW-1:0] head_in  [NUM_LEVELS];
   logic [SlotW-1:0] tail_ff  [NUM_LEVELS];
   logic [SlotW-1:0] tail_in  [NUM_LEVELS];
   logic [CntW-1:0]  count_ff [NUM_LEVELS];
   logic [CntW-1:0]  count_in [NUM_LEVELS];

   // Running task.
   logic                    run_present_ff;
   logic [TASK_ID_BITS-1:0] run_id_ff;
   logic [LvlW-1:0]         run_lvl_ff;

   // Item under work and what the update cycle leaves for the result cycle.
   req_item_type            item_ff;
   logic                    sel_ff;
   logic                    pop_any_ff;
   logic                    bypass_ff;
   logic [TASK_ID_BITS-1:0] byp_id_ff;
   logic [LvlW-1:0]         pop_lvl_ff;
   logic [1:0]              status_ff;

   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   rsp_item_type            rsp_ff;

   logic                    is_sel;
   logic                    in_range;
   logic                    range_err;
   logic                    push_req;
   logic [LvlW-1:0]         push_lvl;
   logic [TASK_ID_BITS-1:0] push_id;
   logic [NUM_LEVELS-1:0]   full;
   logic [NUM_LEVELS-1:0]   nonempty;
   logic                    push_full;
   logic                    do_push;
   logic                    pop_any;
   logic [LvlW-1:0]         pop_lvl;
   logic                    pop;
   logic                    bypass;
   logic [1:0]              status_c;

   logic                    ram_wr_en;
   logic [AddrW-1:0]        ram_wr_addr;
   logic                    ram_rd_en;
   logic [AddrW-1:0]        ram_rd_addr;
   logic [TASK_ID_BITS-1:0] ram_rd_data;
   logic [TASK_ID_BITS-1:0] fetched_id;

   assign is_sel   = (item_ff.op == OP_SELECT);
   assign in_range = ({1'b0, item_ff.task_priority} < LvlLimit);

   always_comb begin
      push_req  = 1'b0;
      push_lvl  = run_lvl_ff;
      push_id   = run_id_ff;
      range_err = 1'b0;
      if (is_sel) begin
         push_req = run_present_ff && item_ff.running_time_left;
      end else if (in_range) begin
         push_req = 1'b1;
         push_lvl = item_ff.task_priority[LvlW-1:0];
         push_id  = item_ff.task_id;
      end else begin
         range_err = 1'b1;
      end
   end

   always_comb begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
         full[l] = (count_ff[l] == CntFull);
      end
   end

   assign push_full = full[push_lvl];
   assign do_push   = push_req && !push_full;

   // A level counts as occupied if it holds entries or takes the push of this item.
   always_comb begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
         nonempty[l] = (count_ff[l] != '0) || (do_push && (push_lvl == LvlW'(l)));
      end
   end

   always_comb begin
      pop_any = 1'b0;
      pop_lvl = '0;
      for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
         if (nonempty[l]) begin
            pop_any = 1'b1;
            pop_lvl = LvlW'(l);
         end
      end
   end

   assign pop = is_sel && pop_any;
   // The pushed task is popped at once when its empty level is the one selected: no memory read.
   assign bypass = do_push && (push_lvl == pop_lvl) && (count_ff[pop_lvl] == '0);

   always_comb begin
      priority if (range_err) begin
         status_c = STATUS_RANGE;
      end else if (push_req && push_full) begin
         status_c = STATUS_FULL;
      end else begin
         status_c = STATUS_OK;
      end
   end

   assign ram_wr_en   = cmd.exec && do_push;
   assign ram_wr_addr = {push_lvl, tail_ff[push_lvl]};
   assign ram_rd_en   = cmd.exec && pop && !bypass;
   assign ram_rd_addr = {pop_lvl, head_ff[pop_lvl]};

   prrs_ram #(
      .WIDTH(TASK_ID_BITS),
      .DEPTH(RamDepth)
   ) u_store (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(push_id),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   always_comb begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
         head_in[l]  = head_ff[l];
         tail_in[l]  = tail_ff[l];
         count_in[l] = count_ff[l];
         if (cmd.exec) begin
            if (do_push && (push_lvl == LvlW'(l))) begin
               tail_in[l] = bump(tail_ff[l]);
            end
            if (pop && (pop_lvl == LvlW'(l))) begin
               head_in[l] = bump(head_ff[l]);
            end
            count_in[l] = count_ff[l]
                        + CntW'(do_push && (push_lvl == LvlW'(l)))
                        - CntW'(pop && (pop_lvl == LvlW'(l)));
         end
      end
   end

   assign fetched_id = bypass_ff ? byp_id_ff : ram_rd_data;

   always_comb begin
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int l = 0; l < NUM_LEVELS; l++) begin
            head_ff[l]  <= '0;
            tail_ff[l]  <= '0;
            count_ff[l] <= '0;
         end
         run_present_ff <= 1'b0;
         run_id_ff      <= '0;
         run_lvl_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         for (int l = 0; l < NUM_LEVELS; l++) begin
            head_ff[l]  <= head_in[l];
            tail_ff[l]  <= tail_in[l];
            count_ff[l] <= count_in[l];
         end
         if (cmd.finish && sel_ff) begin
            run_present_ff <= pop_any_ff;
            run_id_ff      <= pop_any_ff ? fetched_id : '0;
            run_lvl_ff     <= pop_any_ff ? pop_lvl_ff : '0;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff <= req_payload;
      end
      if (cmd.exec) begin
         sel_ff     <= is_sel;
         pop_any_ff <= pop;
         bypass_ff  <= bypass;
         byp_id_ff  <= push_id;
         pop_lvl_ff <= pop_lvl;
         status_ff  <= status_c;
      end
      if (cmd.finish) begin
         rsp_ff.next_valid    <= sel_ff && pop_any_ff;
         rsp_ff.next_task_id  <= (sel_ff && pop_any_ff) ? fetched_id : '0;
         rsp_ff.next_priority <= (sel_ff && pop_any_ff) ? PRIO_BITS'(pop_lvl_ff) : '0;
         rsp_ff.status        <= status_ff;
      end
   end

   assign stat.rsp_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_payload   = rsp_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/priority_round_robin_scheduler_core.sv =====
// Multilevel priority round-robin scheduler with one task FIFO per level.
// Requests arrive on the req_ channel (valid and stall): an add item queues a
// task at the tail of its level, and a select item first requeues the running
// task if it has time left, then pops the most urgent non-empty level.
// Every item gives exactly one result item on the rsp_ channel, holding the
// selected task (selects only) and a status code.
// From acceptance to its result in the output register an item passes the
// accept step that registers it, an update step that moves the queue
// pointers and does the memory write and read together, and a result step
// that takes the registered memory read into the result. A new item is
// accepted only after the last has left its result step, as set by the
// input register in front of the update and by the registered read port of
// the queue memory, whose data is ready only in the cycle after the update.
// The input stalls while an item is at work. When the receiver stalls, the
// result waits in the output register, the next item may still be accepted and
// worked on, and it holds back its own result until the register is free.
// Reset clears all FIFOs and the running task; queue memory is not cleared,
// since only occupied slots are ever read.
`timescale 1ns / 1ps
`default_nettype none

module priority_round_robin_scheduler_core
   import prrs_pkg::*;
#(
   parameter int NUM_LEVELS  = NUM_LEVELS_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_item_type req_payload,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_item_type      rsp_payload
);

   // Commands travel from the controller to the datapath, status comes back.
   cmd_type  cmd;
   stat_type stat;

   prrs_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .stat     (stat),
      .cmd      (cmd)
   );

   // The datapath holds the FIFO pointers, the queue memory, the running task
   // and the output register.
   prrs_datapath #(
      .NUM_LEVELS (NUM_LEVELS),
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_payload(req_payload),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .rsp_payload(rsp_payload)
   );

`ifndef SYNTHESIS
   // Once an item is taken, the input must close until that item is done.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input accepted a second item while one was at work");

   // A fresh result must trace back to an item accepted just before its update and result steps.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 3))
      else $error("result appeared without a matching accepted item");

   // An idle or add result carries no task.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.next_valid) |->
         (rsp_payload.next_task_id == '0 && rsp_payload.next_priority == '0))
      else $error("result without a selected task carries task fields");

   // A range error comes only from an add, which never selects a task.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status == STATUS_RANGE) |-> !rsp_payload.next_valid)
      else $error("range error reported together with a selected task");
`endif

endmodule

`default_nettype wire
